>>> sv/fsg_pkg.sv
// Shared opcodes, field widths and controller/datapath interface types for the sand grid.
package fsg_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 6;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic row_init;
        logic load;
        logic scan;
        logic wr_cur;
        logic wr_below;
        logic row_dec;
        logic check;
        logic set_acc;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_grid;
        logic            scan_none;
        logic            scan_last;
        logic            row_zero;
    } sts_t;

endpackage

>>> sv/fsg_ctrl.sv
// Controller state machine that sequences add, read and tick passes over the grid.
module fsg_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    output logic          m_tvalid,
    input  fsg_pkg::sts_t sts,
    output fsg_pkg::cmd_t cmd
);
    import fsg_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_TRD     = 4'd3;
    localparam logic [3:0] S_TLOAD   = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_WRCUR   = 4'd6;
    localparam logic [3:0] S_WRBELOW = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       mvalid_reg;
    logic       mvalid_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        mvalid_next = mvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_TICK: begin
                        if (sts.scan_none) begin
                            cmd.set_acc = 1'b1;
                            state_next  = S_DONE;
                        end else begin
                            cmd.row_init = 1'b1;
                            state_next   = S_TRD;
                        end
                    end
                    OP_ADD, OP_READ: begin
                        // The memory read of the addressed row happens in this cycle.
                        state_next = sts.in_grid ? S_CHECK : S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
            end
            S_TRD: begin
                state_next = S_TLOAD;
            end
            S_TLOAD: begin
                cmd.load   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_WRCUR;
                end
            end
            S_WRCUR: begin
                cmd.wr_cur = 1'b1;
                state_next = S_WRBELOW;
            end
            S_WRBELOW: begin
                cmd.wr_below = 1'b1;
                if (sts.row_zero) begin
                    cmd.set_acc = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.row_dec = 1'b1;
                    state_next  = S_TRD;
                end
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

>>> sv/fsg_dpath.sv
// Datapath: row memory, working row registers, cell update rule and result registers.
module fsg_dpath #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int MOVE_STEP   = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [fsg_pkg::OP_W-1:0]       in_op,
    input  logic [fsg_pkg::COORD_W-1:0]    in_x,
    input  logic [fsg_pkg::COORD_W-1:0]    in_y,
    input  fsg_pkg::cmd_t                  cmd,
    output fsg_pkg::sts_t                  sts,
    output logic                           out_occupied,
    output logic                           out_accepted
);
    import fsg_pkg::*;

    localparam int CW = $clog2(GRID_WIDTH);
    localparam int RW = $clog2(GRID_HEIGHT);
    localparam int XW = CW + 3;
    localparam int SW = RW + 3;
    localparam bit HAS_SCAN  = (GRID_HEIGHT > MOVE_STEP);
    localparam int START_ROW = HAS_SCAN ? (GRID_HEIGHT - 1 - MOVE_STEP) : 0;

    logic [GRID_WIDTH-1:0] mem [0:GRID_HEIGHT-1];
    logic [GRID_HEIGHT-1:0] valid_reg;

    logic [OP_W-1:0]       op_reg;
    logic [COORD_W-1:0]    x_in_reg;
    logic [COORD_W-1:0]    y_in_reg;
    logic [GRID_WIDTH-1:0] rd_a_reg;
    logic [GRID_WIDTH-1:0] rd_b_reg;
    logic                  rv_a_reg;
    logic                  rv_b_reg;
    logic [GRID_WIDTH-1:0] cur_reg;
    logic [GRID_WIDTH-1:0] cur_next;
    logic [GRID_WIDTH-1:0] below_reg;
    logic [GRID_WIDTH-1:0] below_next;
    logic [CW-1:0]         x_reg;
    logic [RW-1:0]         row_reg;
    logic                  res_occ_reg;
    logic                  res_acc_reg;
    logic                  m_occ_reg;
    logic                  m_acc_reg;

    logic [RW-1:0]         y_addr;
    logic [CW-1:0]         x_addr;
    logic [SW-1:0]         below_sum;
    logic [RW-1:0]         row_below;
    logic [RW-1:0]         addr_a;
    logic [GRID_WIDTH-1:0] row_a;
    logic [GRID_WIDTH-1:0] row_b;
    logic                  cell_bit;
    logic                  we;
    logic [RW-1:0]         waddr;
    logic [GRID_WIDTH-1:0] wdata;
    logic [XW-1:0]         x_right;
    logic [XW-1:0]         x_left;
    logic                  right_in;
    logic                  left_in;
    logic [CW-1:0]         ri;
    logic [CW-1:0]         li;

    assign y_addr    = RW'(y_in_reg);
    assign x_addr    = CW'(x_in_reg);
    assign below_sum = {3'b000, row_reg} + SW'(MOVE_STEP);
    assign row_below = below_sum[RW-1:0];
    assign addr_a    = (op_reg == OP_TICK) ? row_reg : y_addr;

    // Rows that were never written read as empty.
    assign row_a    = rv_a_reg ? rd_a_reg : '0;
    assign row_b    = rv_b_reg ? rd_b_reg : '0;
    assign cell_bit = row_a[x_addr];

    always_comb begin
        we    = 1'b0;
        waddr = row_reg;
        wdata = cur_reg;
        if (cmd.wr_cur) begin
            we = 1'b1;
        end else if (cmd.wr_below) begin
            we    = 1'b1;
            waddr = row_below;
            wdata = below_reg;
        end else if (cmd.check && (op_reg == OP_ADD) && !cell_bit) begin
            we            = 1'b1;
            waddr         = y_addr;
            wdata         = row_a;
            wdata[x_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[row_below];
        rv_a_reg <= valid_reg[addr_a];
        rv_b_reg <= valid_reg[row_below];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // One cell of the update pass, against the two working rows.
    always_comb begin
        x_right    = XW'(x_reg) + XW'(MOVE_STEP);
        x_left     = XW'(x_reg) - XW'(MOVE_STEP);
        right_in   = (x_right < XW'(GRID_WIDTH));
        left_in    = (XW'(x_reg) >= XW'(MOVE_STEP));
        ri         = x_right[CW-1:0];
        li         = x_left[CW-1:0];
        cur_next   = cur_reg;
        below_next = below_reg;
        if (cur_reg[x_reg]) begin
            if (!below_reg[x_reg]) begin
                below_next[x_reg] = 1'b1;
                cur_next[x_reg]   = 1'b0;
            end else if (right_in && !cur_reg[ri] && !below_reg[ri]) begin
                cur_next[ri]    = 1'b1;
                cur_next[x_reg] = 1'b0;
            end else if (left_in && !cur_reg[li] && !below_reg[li]) begin
                cur_next[li]    = 1'b1;
                cur_next[x_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= in_op;
            x_in_reg <= in_x;
            y_in_reg <= in_y;
        end
        if (cmd.load) begin
            cur_reg   <= row_a;
            below_reg <= row_b;
            x_reg     <= '0;
        end else if (cmd.scan) begin
            cur_reg   <= cur_next;
            below_reg <= below_next;
            x_reg     <= x_reg + 1'b1;
        end
        if (cmd.row_init) begin
            row_reg <= RW'(START_ROW);
        end else if (cmd.row_dec) begin
            row_reg <= row_reg - 1'b1;
        end
        if (cmd.accept) begin
            res_occ_reg <= 1'b0;
            res_acc_reg <= 1'b0;
        end else if (cmd.set_acc) begin
            res_acc_reg <= 1'b1;
        end else if (cmd.check) begin
            if (op_reg == OP_READ) begin
                res_occ_reg <= cell_bit;
            end else if (op_reg == OP_ADD) begin
                res_acc_reg <= !cell_bit;
            end
        end
        if (cmd.out_load) begin
            m_occ_reg <= res_occ_reg;
            m_acc_reg <= res_acc_reg;
        end
    end

    assign sts.op        = op_reg;
    assign sts.in_grid   = ({1'b0, x_in_reg} < 7'(GRID_WIDTH)) &&
                           ({3'b000, y_in_reg} < 9'(GRID_HEIGHT));
    assign sts.scan_none = !HAS_SCAN;
    assign sts.scan_last = (x_reg == CW'(GRID_WIDTH - 1));
    assign sts.row_zero  = (row_reg == '0);

    assign out_occupied = m_occ_reg;
    assign out_accepted = m_acc_reg;

endmodule

>>> sv/falling_sand_grid_step.sv
// Top level of the falling-sand grid: one item at a time, result in an output register.
// Add and read: the beat is decoded and, if the cell lies in the grid, its row is read and checked.
// Tick: each row from GRID_HEIGHT - 1 - MOVE_STEP down to 0 is read with the row below it,
// then scanned one cell per cycle and written back with the row below on the memory.
// The next beat can be accepted in the cycle after the result is loaded, even before it is taken.
// Reset (aresetn, synchronous) clears all row valid bits at once: the grid reads empty.
module falling_sand_grid_step #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int MOVE_STEP   = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op [1:0], cell_x [7:2], cell_y [13:8], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // cell_occupied [0], accepted [1], zeros above
);
    import fsg_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic out_occupied;
    logic out_accepted;

    fsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsg_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .MOVE_STEP   (MOVE_STEP)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_op        (s_tdata[1:0]),
        .in_x         (s_tdata[7:2]),
        .in_y         (s_tdata[13:8]),
        .cmd          (cmd),
        .sts          (sts),
        .out_occupied (out_occupied),
        .out_accepted (out_accepted)
    );

    assign m_tdata = {6'b000000, out_accepted, out_occupied};

    // Only one item is worked on at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice without finishing the first item");

    // Ready only drops because a beat was taken.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("ready dropped without an accepted beat");

    // A result never reports both an occupied read and an accepted add or tick.
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("result marks both occupied and accepted");

    // The controller starts a memory update only while an item is in work.
    a_busy_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_cur || cmd.wr_below || cmd.check) |-> !s_tready)
        else $error("grid update issued while idle");

endmodule
